// ===== design/fdps_pkg.sv =====
package fdps_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int ADDR_W = $clog2(MAX_PIXELS);
	localparam int CNT_W = ADDR_W + 1;

	localparam int ACC_W = 34;
	localparam int LOG_W = 22;
	localparam int CLAMP_W = 15;

	localparam logic [17:0] NUM_SCALE = 18'd195075;
	localparam logic [17:0] LOG_SCALE = 18'd197283;
	localparam logic [17:0] SCORE_SCALE = 18'd255744;
	localparam logic [14:0] SCORE_FULL = 15'd25600;
	localparam logic [14:0] MIN_CLAMP_RST = 15'd6400;
	localparam logic [14:0] MAX_CLAMP_RST = 15'd11520;

	localparam logic REG_MIN_CLAMP = 1'b0;
	localparam logic REG_MAX_CLAMP = 1'b1;

	typedef enum logic [3:0] {
		ST_RUN,
		ST_DRAIN,
		ST_SETUP,
		ST_LOGA_GO,
		ST_LOGA_WAIT,
		ST_LOGB_GO,
		ST_LOGB_WAIT,
		ST_SCALE,
		ST_ROUND,
		ST_CLAMP,
		ST_NUMER,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT
	} fdps_state_t;

	typedef enum logic [1:0] {
		LG_IDLE,
		LG_NORM,
		LG_SQR
	} fdps_log_state_t;

	typedef enum logic {
		DV_IDLE,
		DV_RUN
	} fdps_div_state_t;

endpackage

// ===== design/fdps_lane.sv =====
module fdps_lane (
	input  logic [7:0]  cur,
	input  logic [7:0]  prev,
	output logic [15:0] sq
);

	logic [7:0] diff;

	assign diff = (cur > prev) ? (cur - prev) : (prev - cur);
	assign sq = diff * diff;

endmodule

// ===== design/fdps_log2.sv =====
module fdps_log2 (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [fdps_pkg::ACC_W-1:0]   value,
	output logic                         done,
	output logic [fdps_pkg::LOG_W-1:0]   result
);

	fdps_pkg::fdps_log_state_t state_q, state_d;
	logic [fdps_pkg::ACC_W-1:0] x_q;
	logic [5:0]  e_q;
	logic [31:0] m_q;
	logic [15:0] frac_q;
	logic [3:0]  it_q;
	logic        done_q;
	logic [63:0] prod;
	logic [32:0] sq;

	assign prod = m_q * m_q;
	assign sq = prod[63:31];

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdps_pkg::LG_IDLE: if (start) state_d = fdps_pkg::LG_NORM;
			fdps_pkg::LG_NORM: if (x_q[fdps_pkg::ACC_W-1]) state_d = fdps_pkg::LG_SQR;
			fdps_pkg::LG_SQR:  if (it_q == 4'd15) state_d = fdps_pkg::LG_IDLE;
			default:           state_d = fdps_pkg::LG_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdps_pkg::LG_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == fdps_pkg::LG_SQR) && (it_q == 4'd15);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdps_pkg::LG_IDLE: begin
				x_q <= value;
				e_q <= 6'(fdps_pkg::ACC_W - 1);
				frac_q <= '0;
				it_q <= '0;
			end
			fdps_pkg::LG_NORM: begin
				// Shift until the leading one reaches the top; it then sits at bit 31 of m.
				if (x_q[fdps_pkg::ACC_W-1]) begin
					m_q <= x_q[fdps_pkg::ACC_W-1 -: 32];
				end else begin
					x_q <= {x_q[fdps_pkg::ACC_W-2:0], 1'b0};
					e_q <= e_q - 6'd1;
				end
			end
			fdps_pkg::LG_SQR: begin
				if (sq[32]) begin
					m_q <= sq[32:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q <= sq[31:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
				it_q <= it_q + 4'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign result = {e_q, frac_q};

endmodule

// ===== design/fdps_div.sv =====
module fdps_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [33:0] numer,
	input  logic [17:0] denom,
	output logic        done,
	output logic [14:0] quot
);

	fdps_pkg::fdps_div_state_t state_q, state_d;
	logic [33:0] n_q;
	logic [33:0] q_q;
	logic [18:0] rem_q;
	logic [17:0] d_q;
	logic [5:0]  cnt_q;
	logic        done_q;
	logic [18:0] trial;

	assign trial = {rem_q[17:0], n_q[33]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdps_pkg::DV_IDLE: if (start) state_d = fdps_pkg::DV_RUN;
			fdps_pkg::DV_RUN:  if (cnt_q == 6'd33) state_d = fdps_pkg::DV_IDLE;
			default:           state_d = fdps_pkg::DV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdps_pkg::DV_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == fdps_pkg::DV_RUN) && (cnt_q == 6'd33);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdps_pkg::DV_IDLE: begin
				n_q <= numer;
				d_q <= denom;
				rem_q <= '0;
				q_q <= '0;
				cnt_q <= '0;
			end
			fdps_pkg::DV_RUN: begin
				n_q <= {n_q[32:0], 1'b0};
				if (trial >= {1'b0, d_q}) begin
					rem_q <= trial - {1'b0, d_q};
					q_q <= {q_q[32:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q <= {q_q[32:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quot = q_q[14:0];

endmodule

// ===== design/frame_difference_psnr_score_core.sv =====
// Frame difference PSNR motion score.
// Pixels enter on the input channel (in_valid / in_stall), one transfer per
// cycle within a frame; end_of_frame marks the last pixel. Each pixel is
// compared against the same position of the previous frame, held in an
// on-chip memory, by three channel lanes whose squared differences are summed.
// After the end-of-frame transfer in_stall rises while a shared log2 unit
// (normalize, then 16 squaring steps) runs twice and a bit-serial divider
// (34 steps) forms the score. The result appears on the output channel
// (out_valid / out_stall); the log2 runs take longer the further each operand
// must be normalized. Both logarithms are skipped when there is no reference
// or the noise is tiny, and the divider is skipped when the clamp range is
// empty. The output register holds the result while out_stall is high;
// in_stall stays high until that result transfer completes, so each frame's
// computation holds off the next frame's pixels. Reset clears the counters,
// marks no reference frame and restores the clamp registers to 25.0 and
// 45.0 dB; the memory contents are not cleared. cfg_we writes min_clamp
// (index 0) or max_clamp (index 1); the user must write them only while
// idle, as the block itself does not enforce it.
module frame_difference_psnr_score_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [14:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  chan_a,
	input  logic [7:0]  chan_b,
	input  logic [7:0]  chan_c,
	input  logic        end_of_frame,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [14:0] score,
	output logic [14:0] psnr_clamped,
	output logic [33:0] noise_sum,
	output logic        no_reference
);

	localparam int CW = fdps_pkg::CNT_W;
	localparam int AW = fdps_pkg::ADDR_W;
	localparam int NW = fdps_pkg::ACC_W;

	fdps_pkg::fdps_state_t state_q, state_d;

	logic [23:0] frame_mem [fdps_pkg::MAX_PIXELS];

	logic [14:0] min_q, max_q;
	logic [CW-1:0] count_q, prev_count_q;
	logic prev_valid_q, ovf_q;
	logic [NW-1:0] acc_q;

	logic        v_s1;
	logic [23:0] rd_s1;
	logic [7:0]  a_s1, b_s1, c_s1;

	logic [NW-1:0] num_q, noise_q;
	logic          noref_q;
	logic [fdps_pkg::LOG_W-1:0] la_q, lb_q;
	logic [39:0] prod_q;
	logic [15:0] raw_q;
	logic [14:0] psnr_q, score_q;
	logic [33:0] numer_q;
	logic [17:0] den_q;

	logic in_acc, out_acc, in_room;
	logic [15:0] sq_a, sq_b, sq_c;
	logic [17:0] pix_sum;
	logic [NW:0] acc_sum;
	logic [fdps_pkg::LOG_W:0] dlog;
	logic [40:0] rounded;
	logic [15:0] lo_clamped;
	logic [14:0] r_span, dd;

	logic log_start, log_done, div_start, div_done;
	logic [NW-1:0] log_in;
	logic [fdps_pkg::LOG_W-1:0] log_res;
	logic [14:0] quot;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_room = (count_q < CW'(fdps_pkg::MAX_PIXELS));

	fdps_lane u_lane_a (.cur(a_s1), .prev(rd_s1[7:0]),   .sq(sq_a));
	fdps_lane u_lane_b (.cur(b_s1), .prev(rd_s1[15:8]),  .sq(sq_b));
	fdps_lane u_lane_c (.cur(c_s1), .prev(rd_s1[23:16]), .sq(sq_c));

	// Merge the lanes and fold into the saturating frame accumulator.
	assign pix_sum = {2'b0, sq_a} + {2'b0, sq_b} + {2'b0, sq_c};
	assign acc_sum = {1'b0, acc_q} + (NW+1)'(pix_sum);

	assign log_in = (state_q == fdps_pkg::ST_LOGA_GO) ? num_q : noise_q;

	fdps_log2 u_log (
		.clk(clk), .arst_n(arst_n), .start(log_start), .value(log_in),
		.done(log_done), .result(log_res)
	);

	fdps_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .numer(numer_q),
		.denom(den_q), .done(div_done), .quot(quot)
	);

	assign dlog = {1'b0, la_q} - {1'b0, lb_q};
	assign rounded = {1'b0, prod_q} + 41'd8388608;
	assign lo_clamped = (raw_q < {1'b0, min_q}) ? {1'b0, min_q} : raw_q;
	assign r_span = max_q - min_q;
	assign dd = psnr_q - min_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			fdps_pkg::ST_RUN:       if (in_acc && end_of_frame) state_d = fdps_pkg::ST_DRAIN;
			fdps_pkg::ST_DRAIN:     state_d = fdps_pkg::ST_SETUP;
			fdps_pkg::ST_SETUP: begin
				if (!prev_valid_q || ovf_q || count_q != prev_count_q || acc_q <= NW'(1))
					state_d = fdps_pkg::ST_CLAMP;
				else
					state_d = fdps_pkg::ST_LOGA_GO;
			end
			fdps_pkg::ST_LOGA_GO:   state_d = fdps_pkg::ST_LOGA_WAIT;
			fdps_pkg::ST_LOGA_WAIT: if (log_done) state_d = fdps_pkg::ST_LOGB_GO;
			fdps_pkg::ST_LOGB_GO:   state_d = fdps_pkg::ST_LOGB_WAIT;
			fdps_pkg::ST_LOGB_WAIT: if (log_done) state_d = fdps_pkg::ST_SCALE;
			fdps_pkg::ST_SCALE:     state_d = fdps_pkg::ST_ROUND;
			fdps_pkg::ST_ROUND:     state_d = fdps_pkg::ST_CLAMP;
			fdps_pkg::ST_CLAMP:     state_d = fdps_pkg::ST_NUMER;
			fdps_pkg::ST_NUMER: begin
				if (max_q <= min_q) state_d = fdps_pkg::ST_OUT;
				else state_d = fdps_pkg::ST_DIV_GO;
			end
			fdps_pkg::ST_DIV_GO:    state_d = fdps_pkg::ST_DIV_WAIT;
			fdps_pkg::ST_DIV_WAIT:  if (div_done) state_d = fdps_pkg::ST_OUT;
			fdps_pkg::ST_OUT:       if (!out_stall) state_d = fdps_pkg::ST_RUN;
			default:                state_d = fdps_pkg::ST_RUN;
		endcase
	end

	always_comb begin
		in_stall = (state_q != fdps_pkg::ST_RUN);
		out_valid = (state_q == fdps_pkg::ST_OUT);
		log_start = (state_q == fdps_pkg::ST_LOGA_GO) || (state_q == fdps_pkg::ST_LOGB_GO);
		div_start = (state_q == fdps_pkg::ST_DIV_GO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fdps_pkg::ST_RUN;
			min_q <= fdps_pkg::MIN_CLAMP_RST;
			max_q <= fdps_pkg::MAX_CLAMP_RST;
			count_q <= '0;
			prev_count_q <= '0;
			prev_valid_q <= 1'b0;
			ovf_q <= 1'b0;
			acc_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == fdps_pkg::REG_MIN_CLAMP) min_q <= cfg_data;
				if (cfg_index == fdps_pkg::REG_MAX_CLAMP) max_q <= cfg_data;
			end
			v_s1 <= in_acc && in_room && prev_valid_q && (count_q < prev_count_q);
			if (in_acc) begin
				if (in_room) count_q <= count_q + CW'(1);
				else ovf_q <= 1'b1;
			end
			if (v_s1) acc_q <= acc_sum[NW] ? {NW{1'b1}} : acc_sum[NW-1:0];
			if (out_acc) begin
				prev_count_q <= count_q;
				prev_valid_q <= !ovf_q;
				count_q <= '0;
				acc_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end

	// The read returns the previous frame's pixel before this transfer overwrites it.
	always_ff @(posedge clk) begin
		if (in_acc && in_room) begin
			rd_s1 <= frame_mem[count_q[AW-1:0]];
			frame_mem[count_q[AW-1:0]] <= {chan_c, chan_b, chan_a};
		end
		a_s1 <= chan_a;
		b_s1 <= chan_b;
		c_s1 <= chan_c;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			fdps_pkg::ST_SETUP: begin
				num_q <= NW'(fdps_pkg::NUM_SCALE) * NW'(count_q);
				noref_q <= !prev_valid_q || ovf_q || (count_q != prev_count_q);
				if (!prev_valid_q || ovf_q || (count_q != prev_count_q)) begin
					noise_q <= '0;
					raw_q <= {1'b0, min_q};
				end else begin
					noise_q <= acc_q;
					raw_q <= {1'b0, max_q};
				end
			end
			fdps_pkg::ST_LOGA_WAIT: if (log_done) la_q <= log_res;
			fdps_pkg::ST_LOGB_WAIT: if (log_done) lb_q <= log_res;
			fdps_pkg::ST_SCALE: begin
				// A negative difference comes only from truncation and yields zero.
				if (dlog[fdps_pkg::LOG_W]) prod_q <= '0;
				else prod_q <= 40'(dlog[fdps_pkg::LOG_W-1:0]) * 40'(fdps_pkg::LOG_SCALE);
			end
			fdps_pkg::ST_ROUND: raw_q <= rounded[39:24];
			fdps_pkg::ST_CLAMP: begin
				psnr_q <= (lo_clamped > {1'b0, max_q}) ? max_q : lo_clamped[14:0];
			end
			fdps_pkg::ST_NUMER: begin
				score_q <= fdps_pkg::SCORE_FULL;
				numer_q <= 34'(fdps_pkg::SCORE_SCALE) * 34'(dd) + 34'(r_span) * 34'd5;
				den_q <= 18'(r_span) * 18'd10;
			end
			fdps_pkg::ST_DIV_WAIT: if (div_done) score_q <= fdps_pkg::SCORE_FULL - quot;
			default: ;
		endcase
	end

	assign score = score_q;
	assign psnr_clamped = psnr_q;
	assign noise_sum = noise_q;
	assign no_reference = noref_q;

endmodule
